FILE: rtl/core/tba_pkg.sv
// tba_pkg: shared types and constants of the tape block allocator
// owner codes, operation codes and stream field layout
// no dependencies
package tba_pkg;

    // owner code of one map entry, and file or extension number
    typedef logic [4:0] t_code;
    typedef logic [4:0] t_file;

    // operation codes carried in s_axis_tuser
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_START = 2'd0;
    localparam t_mode MODE_ALLOC = 2'd1;
    localparam t_mode MODE_READ  = 2'd2;

    // owner codes that the map holds after reset
    localparam t_code CODE_FREE      = 5'o00;
    localparam t_code CODE_DIRECTORY = 5'o33;
    localparam t_code CODE_RESERVED  = 5'o36;
    localparam t_code CODE_END       = 5'o37;

    // fixed places of the reserved codes
    localparam int RESERVED_FIRST = 1;
    localparam int RESERVED_LAST  = 7;
    localparam int DIR_HOME_BLOCK = 64;
    localparam int END_SPAN       = 8;

    // field widths
    localparam int MODE_W  = 2;
    localparam int NAME_W  = 36;
    localparam int BLOCK_W = 10;
    localparam int CODE_W  = 5;

    // stream layouts, first field in the lowest bits
    localparam int IN_USED_W  = 2 * NAME_W + BLOCK_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;

endpackage

FILE: rtl/core/tba_ram.sv
// tba_ram: generic single write port, single read port ram
// read data registered; no dependencies
module tba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tape_block_allocator.sv
// tape_block_allocator: top level of the tape block allocator
// owner map in tba_ram, directory occupancy and scan state in flip-flops
// depends on tba_pkg and tba_ram
//
// channel   dir   tdata (low bit up)                          tuser
// s_axis    in    name_first, name_second, block_index         mode
// m_axis    out   block_number, file_number, map_code          status
//
// start file passes issue and done states, read map entry issue, read and
// done, allocate block issue, one probe per map entry probed, one bound per
// scan bound reached, then done; the owner map read port sets the probe
// rate at one entry a cycle, bound steps apart. after reset a clearing pass
// writes the reset codes to every entry, while s_axis_tready stays low.
// one item is worked on at a time; a new transfer is taken while the previous result waits on m_axis.
module tape_block_allocator #(
    parameter int MAP_BLOCKS  = 576,
    parameter int DIR_ENTRIES = 23,
    parameter int SCAN_LIMIT  = 568
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // name_first[35:0], name_second[71:36], block_index[81:72], zero pad
    input  logic [tba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  tba_pkg::t_mode                 s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // block_number[9:0], file_number[14:10], map_code[19:15], zero pad
    output logic [tba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic                           m_axis_tuser
);
    import tba_pkg::*;

    localparam int MAP_AW = $clog2(MAP_BLOCKS);
    localparam int PTR_W  = $clog2(SCAN_LIMIT + 1);

    // sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_BOUND = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [MAP_AW-1:0]      r_clr, n_clr;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    logic                   r_back, n_back;
    t_file                  r_cur, n_cur;
    // a directory slot counts as taken once a nonzero word went into it;
    // the name words matter only through that
    logic [DIR_ENTRIES-1:0] r_occ, n_occ;

    // snapshot for undoing a step that finds the directory full
    logic [PTR_W-1:0]       r_sv_ptr;
    logic                   r_sv_back;
    t_file                  r_sv_cur;
    logic [DIR_ENTRIES-1:0] r_sv_occ;

    // captured item
    t_mode                  r_mode;
    logic [BLOCK_W-1:0]     r_idx;
    logic                   r_name_nz;

    // pending result
    logic [BLOCK_W-1:0]     r_res_blk, n_res_blk;
    t_code                  r_res_code, n_res_code;
    logic                   r_res_status, n_res_status;

    // output register
    logic                   r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0]  r_odata;
    logic                   r_ostatus;

    // map ram ports
    logic                   ram_we;
    logic [MAP_AW-1:0]      ram_waddr;
    t_code                  ram_wdata;
    logic [MAP_AW-1:0]      ram_raddr;
    t_code                  ram_rdata;

    logic                   in_xfer;
    logic                   load_out;
    t_code                  clear_code;
    logic                   ptr_in_map;
    logic                   probe_hit;
    logic [PTR_W-1:0]       step_ptr;
    logic                   step_at_bound;
    logic [DIR_ENTRIES-1:0] free_vec;
    logic [DIR_ENTRIES-1:0] first_free;
    logic                   any_free;
    t_file                  free_file;

    tba_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAP_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign load_out      = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);

    // reset code of the map entry under the clearing counter
    always_comb begin
        clear_code = CODE_FREE;
        if (32'(r_clr) >= RESERVED_FIRST && 32'(r_clr) <= RESERVED_LAST) begin
            clear_code = CODE_RESERVED;
        end else if (32'(r_clr) == DIR_HOME_BLOCK) begin
            clear_code = CODE_DIRECTORY;
        end else if (32'(r_clr) >= SCAN_LIMIT && 32'(r_clr) < SCAN_LIMIT + END_SPAN) begin
            clear_code = CODE_END;
        end
    end

    // first free directory slot, numbered from one
    assign free_vec   = ~r_occ;
    assign first_free = free_vec & (~free_vec + DIR_ENTRIES'(1));
    assign any_free   = |free_vec;
    always_comb begin
        free_file = '0;
        for (int s = 0; s < DIR_ENTRIES; s++) begin
            if (first_free[s]) begin
                free_file = free_file | t_file'(s + 1);
            end
        end
    end

    // probe of the entry at the scan pointer; beyond the map counts as taken
    assign ptr_in_map    = 32'(r_ptr) < MAP_BLOCKS;
    assign probe_hit     = ptr_in_map && (ram_rdata == CODE_FREE);
    assign step_ptr      = r_back ? r_ptr - PTR_W'(1) : r_ptr + PTR_W'(1);
    assign step_at_bound = (step_ptr == '0) || (32'(step_ptr) == SCAN_LIMIT);

    // sequencer and scan state
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_ptr        = r_ptr;
        n_back       = r_back;
        n_cur        = r_cur;
        n_occ        = r_occ;
        n_res_blk    = r_res_blk;
        n_res_code   = r_res_code;
        n_res_status = r_res_status;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + MAP_AW'(1);
                if (r_clr == MAP_AW'(MAP_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_res_blk    = '0;
                n_res_code   = CODE_FREE;
                n_res_status = 1'b0;
                if (in_xfer) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                case (r_mode)
                    MODE_START: begin
                        n_state = S_DONE;
                        if (any_free) begin
                            if (r_name_nz) begin
                                n_occ = r_occ | first_free;
                            end
                            n_cur  = free_file;
                            n_ptr  = PTR_W'(1);
                            n_back = 1'b0;
                        end else begin
                            n_res_status = 1'b1;
                        end
                    end
                    MODE_ALLOC: n_state = S_PROBE;
                    MODE_READ:  n_state = S_READ;
                    default:    n_state = S_DONE;
                endcase
            end
            S_PROBE: begin
                if (probe_hit) begin
                    n_res_blk = BLOCK_W'(r_ptr);
                    n_state   = S_DONE;
                end else begin
                    n_ptr = step_ptr;
                    if (step_at_bound) begin
                        n_state = S_BOUND;
                    end
                end
            end
            S_BOUND: begin
                if (any_free) begin
                    // extension entry: first word zero, second the current file
                    if (r_cur != '0) begin
                        n_occ = r_occ | first_free;
                    end
                    n_cur   = free_file;
                    n_back  = !r_back;
                    n_ptr   = r_back ? r_ptr + PTR_W'(1) : r_ptr - PTR_W'(1);
                    n_state = S_PROBE;
                end else begin
                    // undo the extensions claimed during this step
                    n_ptr        = r_sv_ptr;
                    n_back       = r_sv_back;
                    n_cur        = r_sv_cur;
                    n_occ        = r_sv_occ;
                    n_res_status = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_READ: begin
                if (32'(r_idx) < MAP_BLOCKS) begin
                    n_res_code = ram_rdata;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // map access: the only write of an item ends it, so no read of a later
    // item can overlap a pending write
    always_comb begin
        ram_we    = (r_state == S_CLEAR) || ((r_state == S_PROBE) && probe_hit);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : MAP_AW'(r_ptr);
        ram_wdata = (r_state == S_CLEAR) ? clear_code : r_cur;
        case (r_state)
            S_ISSUE: ram_raddr = (r_mode == MODE_READ) ? MAP_AW'(r_idx) : MAP_AW'(r_ptr);
            S_PROBE: ram_raddr = MAP_AW'(n_ptr);
            S_BOUND: ram_raddr = MAP_AW'(n_ptr);
            default: ram_raddr = MAP_AW'(r_ptr);
        endcase
    end

    // output register valid
    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ptr    <= PTR_W'(1);
            r_back   <= 1'b0;
            r_cur    <= '0;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ptr    <= n_ptr;
            r_back   <= n_back;
            r_cur    <= n_cur;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    // item capture, snapshot, pending result and output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode    <= s_axis_tuser;
            r_idx     <= s_axis_tdata[IN_USED_W-1:2*NAME_W];
            r_name_nz <= |s_axis_tdata[2*NAME_W-1:0];
            r_sv_ptr  <= r_ptr;
            r_sv_back <= r_back;
            r_sv_cur  <= r_cur;
            r_sv_occ  <= r_occ;
        end
        r_res_blk    <= n_res_blk;
        r_res_code   <= n_res_code;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_odata   <= {{(OUT_DATA_W - BLOCK_W - 2 * CODE_W){1'b0}},
                          r_res_code, r_cur, r_res_blk};
            r_ostatus <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostatus;

`ifndef NO_ASSERTIONS
    // map is written only by the clearing pass or a successful probe
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || (r_state == S_PROBE && ptr_in_map)))
        else $error("owner map written outside clearing or probe");

    // scan pointer lies strictly inside the scan range between items
    a_ptr_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_ptr != '0 && 32'(r_ptr) < SCAN_LIMIT))
        else $error("scan pointer outside scan range while idle");

    // a directory-full result leaves directory and scan state as before
    a_full_undo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status) |->
            (r_occ == r_sv_occ && r_cur == r_sv_cur && r_ptr == r_sv_ptr))
        else $error("directory full step changed state");
`endif

endmodule
